/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int MODE_W     = 3;
    localparam int POS_W      = 6;
    localparam int ITEM_W     = 32;
    localparam int LEN_W      = 5;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic  ins;
        logic  rem;
        logic  wr;
        t_idx  idx;
        t_word word;
    } t_cell_cmd;

endpackage

/* rtl/ple_cell.sv */
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
(
    input  logic      i_clk,
    input  t_idx      i_index,
    input  t_cell_cmd i_cmd,
    input  t_word     i_lower,
    input  t_word     i_upper,
    output t_word     o_data
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (i_index == i_cmd.idx) begin
                n_data = i_cmd.word;
            end else if (i_index > i_cmd.idx) begin
                n_data = i_lower;
            end
        end else if (i_cmd.rem) begin
            if (i_index >= i_cmd.idx) begin
                n_data = i_upper;
            end
        end else if (i_cmd.wr) begin
            if (i_index == i_cmd.idx) begin
                n_data = i_cmd.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps

// Positional list of up to DEPTH words held in a row of cells, one word per
// cell. A request is a transfer on the slave side; its result appears on the
// master side in the cycle after, and a new request is taken every cycle as long
// as the output register is empty or being drained. Insert and remove shift
// all cells behind the position in parallel. Refused requests (bad position,
// insert into a full list, unused mode) change nothing and report ok=0 with a
// zero word. Every result carries the list length after the request.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [2:0] mode, [8:3] position, [40:9] item, [47:41] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] item_out, [32] ok, [37:33] length, [39:38] zero
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [ITEM_W-1:0] item;
    logic              s_xfer;
    logic              pos_in_list;
    logic              pos_for_ins;
    logic              ins_ok;
    logic              rem_ok;
    logic              rd_ok;
    logic              rep_ok;
    logic              clr;
    logic              req_ok;
    t_idx              idx;
    t_cell_cmd         cmd;
    t_word             cell_data [DEPTH];
    t_word             sel_word;

    t_cnt              r_count;
    t_cnt              n_count;
    logic              r_out_valid;
    logic [ITEM_W-1:0] r_item_out;
    logic              r_ok;
    logic [LEN_W-1:0]  r_length;

    assign mode = i_s_tdata[MODE_W-1:0];
    assign pos  = i_s_tdata[MODE_W+POS_W-1:MODE_W];
    assign item = i_s_tdata[MODE_W+POS_W+ITEM_W-1:MODE_W+POS_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    assign pos_in_list = (pos != '0) && ({1'b0, pos} <= (POS_W+1)'(r_count));
    assign pos_for_ins = (pos != '0) && ({1'b0, pos} <= (POS_W+1)'(r_count) + 1'b1);

    assign ins_ok = (mode == MODE_INSERT) && pos_for_ins && (r_count < t_cnt'(DEPTH));
    assign rem_ok = (mode == MODE_REMOVE) && pos_in_list;
    assign rd_ok  = (mode == MODE_READ) && pos_in_list;
    assign rep_ok = (mode == MODE_REPLACE) && pos_in_list;
    assign clr    = (mode == MODE_CLEAR);
    assign req_ok = ins_ok || rem_ok || rd_ok || rep_ok || clr;

    assign idx = t_idx'(pos - 1'b1);

    always_comb begin
        cmd.ins  = s_xfer && ins_ok;
        cmd.rem  = s_xfer && rem_ok;
        cmd.wr   = s_xfer && rep_ok;
        cmd.idx  = idx;
        cmd.word = t_word'(item);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_word lower;
        t_word upper;
        if (k == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = cell_data[k+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_idx'(k)),
            .i_cmd   (cmd),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (cell_data[k])
        );
    end

    assign sel_word = cell_data[idx];

    always_comb begin
        n_count = r_count;
        if (clr) begin
            n_count = '0;
        end else if (ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (rem_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_item_out <= (rd_ok || rep_ok) ? ITEM_W'(sel_word) : '0;
            r_ok       <= req_ok;
            r_length   <= LEN_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-ITEM_W-1-LEN_W){1'b0}}, r_length, r_ok, r_item_out};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("list count above depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && clr |=> r_count == '0)
        else $error("clear did not empty the list");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && ins_ok |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    a_length_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_length == LEN_W'(r_count))
        else $error("reported length differs from count");

endmodule
